// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions with an active-low reset disable.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/pct_pkg.sv -----
// ---------------------------------------------------------------------------
// pct_pkg
// Types and constants shared by the packed component table modules.
// ---------------------------------------------------------------------------
package pct_pkg;

    localparam int MAX_ENTITIES = 1024;
    localparam int ENT_W        = $clog2(MAX_ENTITIES);
    localparam int CNT_W        = ENT_W + 1;
    localparam int VALUE_W      = 32;

    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_REMOVE  = 2'd1,
        REQ_GET     = 2'd2,
        REQ_DESTROY = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ALREADY = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        t_req_type    req_type;
        logic [9:0]   entity_id;
        logic [31:0]  component_value;
    } t_req;

    typedef struct packed {
        t_status      status;
        logic [31:0]  read_value;
        logic [10:0]  live_count;
    } t_rsp;

    typedef struct packed {
        logic             present;
        logic [ENT_W-1:0] slot;
    } t_ent_row;

    typedef struct packed {
        logic [ENT_W-1:0]   owner;
        logic [VALUE_W-1:0] value;
    } t_dense_row;

    typedef struct packed {
        logic clear;
        logic accept;
        logic eval;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_sts;

endpackage

// ----- hdl/pct_ctrl.sv -----
// ---------------------------------------------------------------------------
// pct_ctrl
// Sequencer for the table: post-reset sweep, accept, evaluate, deliver.
// ---------------------------------------------------------------------------
module pct_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  pct_pkg::t_sts i_sts,
    output logic          o_in_stall,
    output pct_pkg::t_cmd o_cmd
);
    import pct_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EVAL  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_cmd.clear  = (r_state == S_CLEAR);
    assign o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.eval   = (r_state == S_EVAL);
    assign o_cmd.finish = (r_state == S_DONE) && i_sts.out_free;

endmodule

// ----- hdl/pct_dpath.sv -----
// ---------------------------------------------------------------------------
// pct_dpath
// Entity and dense memories, live count, and the result word register.
// ---------------------------------------------------------------------------
module pct_dpath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pct_pkg::t_cmd i_cmd,
    input  pct_pkg::t_req i_req,
    output pct_pkg::t_sts o_sts,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output pct_pkg::t_rsp o_rsp
);
    import pct_pkg::*;

    // Entity map: presence bit and dense slot. Dense array: owner and value.
    t_ent_row   r_ent_mem   [MAX_ENTITIES];
    t_dense_row r_dense_mem [MAX_ENTITIES];

    t_ent_row         r_ent_rd;
    t_dense_row       r_dense_rd;
    t_req             r_req;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [ENT_W-1:0] r_clr_addr;
    t_status          r_status;
    t_status          n_status;
    logic             r_get_ok;
    logic             n_get_ok;
    logic             r_drop;
    logic             n_drop;
    logic             r_out_valid;
    t_rsp             r_out;

    logic             ent_we;
    logic [ENT_W-1:0] ent_waddr;
    t_ent_row         ent_wdata;
    logic             dense_we;
    logic [ENT_W-1:0] dense_waddr;
    t_dense_row       dense_wdata;
    logic             dense_re;
    logic [ENT_W-1:0] dense_raddr;
    logic [ENT_W-1:0] last_slot;
    logic             out_free;

    assign last_slot = ENT_W'(r_count - CNT_W'(1));
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        ent_we      = 1'b0;
        ent_waddr   = r_req.entity_id;
        ent_wdata   = '0;
        dense_we    = 1'b0;
        dense_waddr = r_ent_rd.slot;
        dense_wdata = r_dense_rd;
        dense_re    = 1'b0;
        dense_raddr = last_slot;
        n_count     = r_count;
        n_status    = r_status;
        n_get_ok    = r_get_ok;
        n_drop      = r_drop;

        if (i_cmd.clear) begin
            ent_we    = 1'b1;
            ent_waddr = r_clr_addr;
        end

        // The last dense row is fetched up front in case this is a removal.
        if (i_cmd.accept) begin
            dense_re = 1'b1;
            n_status = ST_OK;
            n_get_ok = 1'b0;
            n_drop   = 1'b0;
        end

        if (i_cmd.eval) begin
            case (r_req.req_type)
                REQ_INSERT: begin
                    if (r_ent_rd.present) begin
                        n_status = ST_ALREADY;
                    end else if (r_count >= CNT_W'(MAX_ENTITIES)) begin
                        n_status = ST_FULL;
                    end else begin
                        ent_we              = 1'b1;
                        ent_wdata.present   = 1'b1;
                        ent_wdata.slot      = r_count[ENT_W-1:0];
                        dense_we            = 1'b1;
                        dense_waddr         = r_count[ENT_W-1:0];
                        dense_wdata.owner   = r_req.entity_id;
                        dense_wdata.value   = r_req.component_value;
                        n_count             = r_count + CNT_W'(1);
                    end
                end
                REQ_REMOVE, REQ_DESTROY: begin
                    if (r_ent_rd.present) begin
                        // Move the last row into the hole and repoint its owner.
                        dense_we          = 1'b1;
                        ent_we            = 1'b1;
                        ent_waddr         = r_dense_rd.owner;
                        ent_wdata.present = 1'b1;
                        ent_wdata.slot    = r_ent_rd.slot;
                        n_count           = r_count - CNT_W'(1);
                        n_drop            = 1'b1;
                    end else if (r_req.req_type == REQ_REMOVE) begin
                        n_status = ST_ABSENT;
                    end
                end
                REQ_GET: begin
                    if (r_ent_rd.present) begin
                        dense_re    = 1'b1;
                        dense_raddr = r_ent_rd.slot;
                        n_get_ok    = 1'b1;
                    end else begin
                        n_status = ST_ABSENT;
                    end
                end
                default: begin
                end
            endcase
        end

        // Clearing the removed entity comes after the owner update, so a
        // removal of the last row still leaves the entity absent.
        if (i_cmd.finish && r_drop) begin
            ent_we    = 1'b1;
            ent_waddr = r_req.entity_id;
            ent_wdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            r_ent_mem[ent_waddr] <= ent_wdata;
        end
        if (i_cmd.accept) begin
            r_ent_rd <= r_ent_mem[i_req.entity_id];
        end
    end

    always_ff @(posedge i_clk) begin
        if (dense_we) begin
            r_dense_mem[dense_waddr] <= dense_wdata;
        end
        if (dense_re) begin
            r_dense_rd <= r_dense_mem[dense_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_req;
        end
        r_status <= n_status;
        r_get_ok <= n_get_ok;
        r_drop   <= n_drop;
        if (i_cmd.finish) begin
            r_out.status     <= r_status;
            r_out.read_value <= r_get_ok ? r_dense_rd.value : '0;
            r_out.live_count <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + ENT_W'(1);
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.clear_last = (r_clr_addr == ENT_W'(MAX_ENTITIES - 1));
    assign o_sts.out_free   = out_free;
    assign o_out_valid      = r_out_valid;
    assign o_rsp            = r_out;

endmodule

// ----- hdl/packed_component_table_top.sv -----
// ---------------------------------------------------------------------------
// packed_component_table_top
// Dense component table keyed by entity number, with swap-on-remove.
// ---------------------------------------------------------------------------
// Each request word gives exactly one response word. After reset the block
// sweeps its entity presence memory, one entry per cycle, and holds the
// request channel stalled until the sweep ends. A request then goes from
// acceptance to a loaded response through the registered read of the
// entity memory (and of the last dense row), the decision and the memory
// writes (or the dense row read for a get), and, when the output is free,
// the response load and, on a removal, the clearing of the entity entry.
// The response register lets the next request be accepted while a
// response still waits on the output.
module packed_component_table_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  pct_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output pct_pkg::t_rsp o_out_data
);
    import pct_pkg::*;

    t_cmd cmd;
    t_sts sts;

    pct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    pct_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (i_in_data),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_rsp       (o_out_data)
    );

`include "assert_macros.svh"

    `PCT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `PCT_ASSERT_NEXT(a_sweep_after_reset, i_clk, 1'b1, !i_rst_n, o_in_stall)
    `PCT_ASSERT_SAME(a_full_count, i_clk, i_rst_n, o_out_valid && o_out_data.status == ST_FULL, o_out_data.live_count == CNT_W'(MAX_ENTITIES))
    `PCT_ASSERT_SAME(a_error_zero_value, i_clk, i_rst_n, o_out_valid && o_out_data.status != ST_OK, o_out_data.read_value == '0)

endmodule
